// File: rtl/core/glq_pkg.sv
// ----------------------------------------------------------------------------
// glq_pkg: shared definitions for the glyph quad layout block
// Widths, character codes, register indexes and saturation helpers.
// ----------------------------------------------------------------------------
package glq_pkg;

    localparam int MAX_LINES = 64;
    localparam int LINE_AW   = $clog2(MAX_LINES);
    localparam logic [LINE_AW-1:0] LINE_LAST = LINE_AW'(MAX_LINES - 1);

    localparam int MUL_AW = 24;
    localparam int MUL_BW = 26;
    localparam int MUL_PW = MUL_AW + 1 + MUL_BW;
    localparam int WIDE_W = MUL_PW + 1;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_PRINT = 8'h20;

    localparam logic [2:0] CFG_SCALE    = 3'd0;
    localparam logic [2:0] CFG_FLH      = 3'd1;
    localparam logic [2:0] CFG_LINE_GAP = 3'd2;
    localparam logic [2:0] CFG_ANCHOR_H = 3'd3;
    localparam logic [2:0] CFG_ANCHOR_V = 3'd4;
    localparam logic [2:0] CFG_SPACE    = 3'd5;

    localparam logic [19:0] FIELD20_MAX = 20'hFFFFF;

    typedef logic signed [WIDE_W-1:0] wide_t;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input wide_t v);
        logic signed [31:0] r;
        if (v > wide_t'(32'sh7FFFFFFF)) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -wide_t'(33'sh080000000)) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [19:0] sat20(input logic [21:0] v);
        logic [19:0] r;
        if (v > {2'b00, FIELD20_MAX}) begin
            r = FIELD20_MAX;
        end else begin
            r = v[19:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/glyph_quad_layout_top.sv
// ----------------------------------------------------------------------------
// glyph_quad_layout_top: two-pass text layout producing glyph quads
// Measures a string, then places its glyphs as scaled, anchored quads.
// ----------------------------------------------------------------------------
// Usage. Characters arrive as beats on the s_ channel together with their font
// metrics. A beat with s_tuser low belongs to the measure pass: it updates the
// run widths, line heights and the line table, and the beat with s_tlast high
// closes the string and works out the anchor offsets. A beat with s_tuser high
// belongs to the place pass: each printable character yields one beat on the
// m_ channel with the four quad edges in signed Q16.16; tab, newline and
// vertical tab only move the pen and yield nothing.
// Timing. Everything goes through one shared 24 x 26 bit multiplier under a
// small sequencer, so s_tready is high only while the sequencer is idle.
// A printable place beat steps through P0 to P5 and raises m_tvalid as P5
// ends; the next beat is accepted only once the sequencer is idle again.
// A tab runs T0-T1, a newline or vertical tab L0-L3, a plain measure beat
// M0, a measure newline M0-M1, and a closing one adds F0-F4 for the anchors.
// The result sits in an output register; the next beat is accepted while it
// waits, but a further printable beat holds in its first step until the
// receiver has taken the pending result, so a stall only blocks new quads.
// Reset (aresetn low, synchronous) clears the pass state, the pen and the
// anchors and loads the register defaults. The line table is not cleared.
// Configuration writes on cfg_we take effect at once; write only when idle.
// ----------------------------------------------------------------------------
module glyph_quad_layout_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [23:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // char_code, glyph_advance, glyph_bearing_x, glyph_bearing_y,
    // glyph_width, glyph_height (8 bits each, lowest first)
    input  logic [47:0]  s_tdata,
    input  logic         s_tuser,   // op
    input  logic         s_tlast,   // last_char
    output logic         m_tvalid,
    input  logic         m_tready,
    // glyph_code [7:0], left_edge, right_edge, top_edge, bottom_edge (32 each)
    output logic [135:0] m_tdata,
    output logic         m_tuser    // line_overflow
);
    import glq_pkg::*;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_P0   = 5'd1;
    localparam logic [4:0] ST_P1   = 5'd2;
    localparam logic [4:0] ST_P2   = 5'd3;
    localparam logic [4:0] ST_P3   = 5'd4;
    localparam logic [4:0] ST_P4   = 5'd5;
    localparam logic [4:0] ST_P5   = 5'd6;
    localparam logic [4:0] ST_T0   = 5'd7;
    localparam logic [4:0] ST_T1   = 5'd8;
    localparam logic [4:0] ST_L0   = 5'd9;
    localparam logic [4:0] ST_L1   = 5'd10;
    localparam logic [4:0] ST_L2   = 5'd11;
    localparam logic [4:0] ST_L3   = 5'd12;
    localparam logic [4:0] ST_M0   = 5'd13;
    localparam logic [4:0] ST_M1   = 5'd14;
    localparam logic [4:0] ST_F0   = 5'd15;
    localparam logic [4:0] ST_F1   = 5'd16;
    localparam logic [4:0] ST_F2   = 5'd17;
    localparam logic [4:0] ST_F3   = 5'd18;
    localparam logic [4:0] ST_F4   = 5'd19;

    // Configuration registers.
    logic [23:0] scale_reg;
    logic [7:0]  flh_reg;
    logic [15:0] gap_reg;
    logic [1:0]  anc_h_reg;
    logic [1:0]  anc_v_reg;
    logic [7:0]  space_reg;

    // Latched input beat.
    logic [7:0]        code_reg;
    logic [7:0]        adv_reg;
    logic signed [7:0] bx_reg;
    logic [7:0]        by_reg;
    logic [7:0]        gw_reg;
    logic [7:0]        gh_reg;
    logic              last_reg;

    // Layout state.
    logic [4:0]          state_reg;
    logic [7:0]          cur_asc_reg;
    logic [7:0]          cur_desc_reg;
    logic [19:0]         run_w_reg;
    logic [19:0]         max_w_reg;
    logic [19:0]         tot_h_reg;
    logic [LINE_AW-1:0]  line_cnt_reg;
    logic [LINE_AW-1:0]  place_line_reg;
    logic signed [31:0]  pen_x_reg;
    logic signed [31:0]  pen_y_reg;
    logic signed [31:0]  anc_x_reg;
    logic signed [31:0]  anc_y_reg;
    logic                ovf_reg;
    logic                fresh_reg;
    wide_t               acc_reg;
    logic [7:0]          desc_hold_reg;

    // Output register.
    logic               m_valid_reg;
    logic [7:0]         m_code_reg;
    logic signed [31:0] m_left_reg;
    logic signed [31:0] m_right_reg;
    logic signed [31:0] m_top_reg;
    logic signed [31:0] m_bottom_reg;
    logic               m_ovf_reg;

    // Shared multiplier.
    logic [MUL_AW-1:0]        mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [MUL_PW-1:0] mul_p;
    wide_t                    prod;

    // Line table: ascent in the upper byte, descent in the lower.
    logic               ram_we;
    logic [LINE_AW-1:0] ram_waddr;
    logic [15:0]        ram_wdata;
    logic [LINE_AW-1:0] ram_raddr;
    logic [15:0]        ram_rdata;
    logic [7:0]         rd_asc;
    logic [7:0]         rd_desc;

    logic               s_fire;
    logic               is_nl;
    logic               is_vt;
    logic               merge;
    logic [19:0]        width_max;
    logic [19:0]        height_sum;
    logic [1:0]         anc_h_eff;
    logic [1:0]         anc_v_eff;
    logic [7:0]         in_desc;
    wide_t              base_x;
    wide_t              base_y;
    logic [LINE_AW-1:0] next_line;

    glq_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    glq_ram #(
        .WIDTH (16),
        .DEPTH (MAX_LINES)
    ) u_lines (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_bottom_reg, m_top_reg, m_right_reg, m_left_reg, m_code_reg};
    assign m_tuser  = m_ovf_reg;

    assign prod    = WIDE_W'(mul_p);
    assign rd_asc  = ram_rdata[15:8];
    assign rd_desc = ram_rdata[7:0];
    assign is_nl   = (code_reg == CHAR_NL);
    assign is_vt   = (code_reg == CHAR_VT);
    assign in_desc = (gh_reg > by_reg) ? (gh_reg - by_reg) : 8'd0;

    assign width_max  = (max_w_reg > run_w_reg) ? max_w_reg : run_w_reg;
    assign height_sum = sat20(22'(tot_h_reg) + 22'(cur_asc_reg) + 22'(cur_desc_reg));
    assign anc_h_eff  = (anc_h_reg > 2'd2) ? 2'd2 : anc_h_reg;
    assign anc_v_eff  = (anc_v_reg > 2'd2) ? 2'd2 : anc_v_reg;
    assign next_line  = (place_line_reg == LINE_LAST) ? LINE_LAST
                                                      : place_line_reg + 1'b1;

    assign base_x = WIDE_W'(anc_x_reg) + WIDE_W'(pen_x_reg);
    assign base_y = WIDE_W'(anc_y_reg) + WIDE_W'(pen_y_reg);

    // The last table entry takes the maximum once the table has overflowed.
    assign merge = (line_cnt_reg == LINE_LAST) &&
                   ((state_reg == ST_M1) || ovf_reg);

    always_comb begin
        mul_a = scale_reg;
        mul_b = '0;
        case (state_reg)
            ST_P0: mul_b = MUL_BW'(bx_reg);
            ST_P1: mul_b = MUL_BW'(bx_reg) + MUL_BW'($signed({1'b0, gw_reg}));
            ST_P2: mul_b = MUL_BW'($signed({1'b0, by_reg}));
            ST_P3: mul_b = MUL_BW'($signed({1'b0, by_reg}))
                         - MUL_BW'($signed({1'b0, gh_reg}));
            ST_P4: mul_b = MUL_BW'($signed({1'b0, adv_reg}));
            ST_T0: mul_b = MUL_BW'($signed({1'b0, space_reg, 2'b00}));
            ST_L0: begin
                mul_a = MUL_AW'(gap_reg);
                mul_b = MUL_BW'($signed({1'b0, flh_reg}));
            end
            ST_L1: mul_b = MUL_BW'($signed({1'b0, mul_p[23:0]}));
            ST_L2: mul_b = MUL_BW'($signed({1'b0, 9'(desc_hold_reg) + 9'(rd_asc)}));
            ST_M0: begin
                mul_a = MUL_AW'(gap_reg[15:8]);
                mul_b = MUL_BW'($signed({1'b0, flh_reg}));
            end
            ST_F0: mul_b = MUL_BW'($signed({1'b0, 22'(width_max) * 22'(anc_h_eff)}));
            ST_F1: mul_b = MUL_BW'($signed({1'b0,
                                   22'(height_sum) * 22'(2'd2 - anc_v_eff)}));
            ST_F3: mul_b = MUL_BW'($signed({1'b0, rd_asc}));
            default: mul_b = '0;
        endcase
    end

    always_comb begin
        ram_raddr = '0;
        case (state_reg)
            ST_M0:   ram_raddr = LINE_LAST;
            ST_F0:   ram_raddr = line_cnt_reg;
            ST_L0:   ram_raddr = place_line_reg;
            ST_L1:   ram_raddr = next_line;
            default: ram_raddr = '0;
        endcase
    end

    assign ram_we    = (state_reg == ST_M1) || (state_reg == ST_F1);
    assign ram_waddr = line_cnt_reg;
    assign ram_wdata = {
        (merge && (rd_asc > cur_asc_reg)) ? rd_asc : cur_asc_reg,
        (merge && (rd_desc > cur_desc_reg)) ? rd_desc : cur_desc_reg
    };

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= 24'd65536;
            flh_reg   <= 8'd16;
            gap_reg   <= 16'd51;
            anc_h_reg <= 2'd0;
            anc_v_reg <= 2'd0;
            space_reg <= 8'd8;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_SCALE:    scale_reg <= cfg_wdata;
                CFG_FLH:      flh_reg   <= cfg_wdata[7:0];
                CFG_LINE_GAP: gap_reg   <= cfg_wdata[15:0];
                CFG_ANCHOR_H: anc_h_reg <= cfg_wdata[1:0];
                CFG_ANCHOR_V: anc_v_reg <= cfg_wdata[1:0];
                CFG_SPACE:    space_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Payload registers of the latched beat and the output quad.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            code_reg <= s_tdata[7:0];
            adv_reg  <= s_tdata[15:8];
            bx_reg   <= $signed(s_tdata[23:16]);
            by_reg   <= s_tdata[31:24];
            gw_reg   <= s_tdata[39:32];
            gh_reg   <= s_tdata[47:40];
            last_reg <= s_tlast;
        end
        case (state_reg)
            ST_P1: m_left_reg   <= sat32(base_x + prod);
            ST_P2: m_right_reg  <= sat32(base_x + prod);
            ST_P3: m_top_reg    <= sat32(base_y + prod);
            ST_P4: m_bottom_reg <= sat32(base_y + prod);
            ST_P5: begin
                m_code_reg <= code_reg;
                m_ovf_reg  <= ovf_reg;
            end
            ST_L1: desc_hold_reg <= rd_desc;
            ST_L2: acc_reg <= prod >>> 8;
            ST_F2: acc_reg <= prod >>> 1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cur_asc_reg    <= '0;
            cur_desc_reg   <= '0;
            run_w_reg      <= '0;
            max_w_reg      <= '0;
            tot_h_reg      <= '0;
            line_cnt_reg   <= '0;
            place_line_reg <= '0;
            pen_x_reg      <= '0;
            pen_y_reg      <= '0;
            anc_x_reg      <= '0;
            anc_y_reg      <= '0;
            ovf_reg        <= 1'b0;
            fresh_reg      <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (!s_tuser) begin
                            state_reg <= ST_M0;
                        end else if (s_tdata[7:0] >= CHAR_PRINT) begin
                            state_reg <= ST_P0;
                        end else if (s_tdata[7:0] == CHAR_TAB) begin
                            state_reg <= ST_T0;
                        end else if (s_tdata[7:0] == CHAR_NL ||
                                     s_tdata[7:0] == CHAR_VT) begin
                            state_reg <= ST_L0;
                        end
                    end
                end
                ST_P0: begin
                    if (!m_valid_reg) begin
                        state_reg <= ST_P1;
                    end
                end
                ST_P1: state_reg <= ST_P2;
                ST_P2: state_reg <= ST_P3;
                ST_P3: state_reg <= ST_P4;
                ST_P4: state_reg <= ST_P5;
                ST_P5: begin
                    pen_x_reg   <= sat32(WIDE_W'(pen_x_reg) + prod);
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_IDLE;
                end
                ST_T0: state_reg <= ST_T1;
                ST_T1: begin
                    pen_x_reg <= sat32(WIDE_W'(pen_x_reg) + prod);
                    state_reg <= ST_IDLE;
                end
                ST_L0: state_reg <= ST_L1;
                ST_L1: state_reg <= ST_L2;
                ST_L2: state_reg <= ST_L3;
                ST_L3: begin
                    pen_y_reg <= sat32(WIDE_W'(pen_y_reg) - (acc_reg + prod));
                    if (is_nl) begin
                        pen_x_reg <= '0;
                    end
                    if (place_line_reg != LINE_LAST) begin
                        place_line_reg <= place_line_reg + 1'b1;
                    end
                    state_reg <= ST_IDLE;
                end
                ST_M0: begin
                    fresh_reg <= 1'b0;
                    if (fresh_reg) begin
                        ovf_reg <= 1'b0;
                    end
                    if (is_nl) begin
                        max_w_reg <= width_max;
                        run_w_reg <= '0;
                    end else begin
                        run_w_reg <= sat20(22'(run_w_reg) + 22'(adv_reg));
                    end
                    if (is_nl || is_vt) begin
                        if (line_cnt_reg == LINE_LAST) begin
                            ovf_reg <= 1'b1;
                        end
                        state_reg <= ST_M1;
                    end else begin
                        if (by_reg > cur_asc_reg) begin
                            cur_asc_reg <= by_reg;
                        end
                        if (in_desc > cur_desc_reg) begin
                            cur_desc_reg <= in_desc;
                        end
                        state_reg <= last_reg ? ST_F0 : ST_IDLE;
                    end
                end
                ST_M1: begin
                    tot_h_reg <= sat20(22'(tot_h_reg) + 22'(cur_asc_reg)
                                       + 22'(cur_desc_reg) + 22'(mul_p[15:0]));
                    if (line_cnt_reg != LINE_LAST) begin
                        line_cnt_reg <= line_cnt_reg + 1'b1;
                    end
                    cur_asc_reg  <= '0;
                    cur_desc_reg <= '0;
                    state_reg    <= last_reg ? ST_F0 : ST_IDLE;
                end
                ST_F0: state_reg <= ST_F1;
                ST_F1: begin
                    anc_x_reg <= sat32(-(prod >>> 1));
                    state_reg <= ST_F2;
                end
                ST_F2: state_reg <= ST_F3;
                ST_F3: state_reg <= ST_F4;
                ST_F4: begin
                    anc_y_reg      <= sat32(acc_reg - prod);
                    pen_x_reg      <= '0;
                    pen_y_reg      <= '0;
                    place_line_reg <= '0;
                    cur_asc_reg    <= '0;
                    cur_desc_reg   <= '0;
                    run_w_reg      <= '0;
                    max_w_reg      <= '0;
                    tot_h_reg      <= '0;
                    line_cnt_reg   <= '0;
                    fresh_reg      <= 1'b1;
                    state_reg      <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // A new quad is only ever presented at the end of the place sequence.
    a_quad_from_place: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_P5)
        else $error("result beat raised outside the place sequence");

    // The edges are written into the output register only while it is empty.
    a_edges_into_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_P1 || state_reg == ST_P4) |-> !m_valid_reg)
        else $error("quad edges overwrite a pending result");

    // Closing a string returns the pen to the origin and the first line.
    a_finalise_clears_pen: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_F4 |=> (pen_x_reg == 32'sd0 && pen_y_reg == 32'sd0
                                && place_line_reg == '0 && fresh_reg))
        else $error("pen not cleared after string close");

endmodule

// File: rtl/core/glq_ram.sv
// ----------------------------------------------------------------------------
// glq_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module glq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/core/glq_mul.sv
// ----------------------------------------------------------------------------
// glq_mul: shared registered multiplier
// Unsigned 24-bit operand times signed 26-bit operand, product registered.
// ----------------------------------------------------------------------------
module glq_mul (
    input  logic                                 aclk,
    input  logic [glq_pkg::MUL_AW-1:0]          a,
    input  logic signed [glq_pkg::MUL_BW-1:0]   b,
    output logic signed [glq_pkg::MUL_PW-1:0]   p
);
    import glq_pkg::*;

    logic signed [MUL_AW:0] a_s;

    assign a_s = $signed({1'b0, a});

    // Both operands are widened to the full product width before the multiply.
    always_ff @(posedge aclk) begin
        p <= MUL_PW'(a_s) * MUL_PW'(b);
    end
endmodule
